@@ rtl/pcmp_pkg.sv @@
// pcmp_pkg: types and constants for the pattern cell mask packer
// channel memory entry layout, field codes and the byte hand-off to the serializer
// no dependencies
`default_nettype none

package pcmp_pkg;

  // field codes that mean "nothing in this column"
  localparam logic [7:0] NOTE_NONE = 8'd253;
  localparam logic [7:0] INS_NONE  = 8'd0;
  localparam logic [7:0] VOL_NONE  = 8'd255;
  localparam logic [7:0] CMD_NONE  = 8'd0;
  localparam logic [7:0] VAL_NONE  = 8'd0;

  // mask bits
  localparam int MASK_NEW_NOTE = 0;
  localparam int MASK_NEW_INS  = 1;
  localparam int MASK_NEW_VOL  = 2;
  localparam int MASK_NEW_FX   = 3;
  localparam int MASK_REP_NOTE = 4;
  localparam int MASK_REP_INS  = 5;
  localparam int MASK_REP_VOL  = 6;
  localparam int MASK_REP_FX   = 7;

  // stream bytes
  localparam logic [7:0] ROW_END_BYTE   = 8'h00;
  localparam logic       HEAD_MASK_FLAG = 1'b1;

  // one cell plus the row end yields at most this many bytes
  localparam int MAX_BYTES = 8;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int POS_W     = $clog2(MAX_BYTES);

  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic [POS_W-1:0]               pos_t;
  typedef logic [MAX_BYTES-1:0][7:0]      byte_buf_t;

  // per-channel memory of the last values sent
  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] note;
    logic [7:0] ins;
    logic [7:0] vol;
    logic [7:0] cmd;
    logic [7:0] val;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    mask: 8'd0,
    note: NOTE_NONE,
    ins:  INS_NONE,
    vol:  VOL_NONE,
    cmd:  CMD_NONE,
    val:  VAL_NONE
  };

  // byte group handed from the cell stage to the serializer
  typedef struct packed {
    logic      valid;
    cnt_t      cnt;
    byte_buf_t bytes;
  } ser_load_t;

endpackage

`default_nettype wire

@@ rtl/pcmp_byte_ser.sv @@
// pcmp_byte_ser: turns a group of up to MAX_BYTES bytes into a byte stream
// marks the final byte of each group with tlast; depends on pcmp_pkg
`default_nettype none

module pcmp_byte_ser
  import pcmp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ser_load_t load,
  output logic           free,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  output logic [7:0]     m_tdata,   // out_byte
  output logic           m_tlast    // last_of_item
);

  logic      busy;
  byte_buf_t bytes;
  pos_t      pos;
  pos_t      last_pos;
  logic      advance;

  assign advance  = busy && m_tready;
  assign free     = !busy || (advance && m_tlast);
  assign m_tvalid = busy;
  assign m_tdata  = bytes[pos];
  assign m_tlast  = (pos == last_pos);

  // control: take a new group when the current one is done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (free && load.valid) begin
      busy <= 1'b1;
    end else if (advance && m_tlast) begin
      busy <= 1'b0;
    end
  end

  // payload and byte position
  always_ff @(posedge clk) begin
    if (free && load.valid) begin
      bytes    <= load.bytes;
      pos      <= '0;
      last_pos <= POS_W'(load.cnt - cnt_t'(1));
    end else if (advance && !m_tlast) begin
      pos <= pos + pos_t'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/pattern_cell_mask_packer_unit.sv @@
// pattern_cell_mask_packer_unit: packs tracker pattern cells into a byte stream
// top level; depends on pcmp_pkg and pcmp_byte_ser
//
// One cell enters per transaction on the slave side; the master side gives
// the packed bytes one per transaction, tlast on the final byte of each cell.
// The channel memory is read when a cell is accepted and written back when
// the cell hands its bytes to the serializer from the cell stage register;
// a cell on the same channel right behind it gets the new entry by forwarding.
// A cell waits in the memory stage while the serializer still sends the
// previous cell's bytes; the hand-off overlaps the previous cell's last
// output byte. Each cell yields 0 to 8 bytes, sent one per transaction on
// the byte-wide output port as m_tready allows, which sets the sustained
// rate; a new cell can enter while the previous cell's bytes are still sent.
// first_of_pattern resets every channel at once (per-channel valid bits),
// with no clearing pass.
`default_nettype none

module pattern_cell_mask_packer_unit
  import pcmp_pkg::*;
#(
  parameter int CHANNELS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // channel, note, instrument, volume,
                                      // effect_command, effect_value, 2 zero bits
  input  wire logic        s_tuser,   // first_of_pattern
  input  wire logic        s_tlast,   // end_of_row
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic             m_tlast    // last_of_item
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // input unpacking
  logic [5:0] in_channel;
  logic       in_range;
  logic [AW-1:0] in_idx;
  logic       accept;

  assign in_channel = s_tdata[5:0];
  assign in_range   = (int'(in_channel) < CHANNELS);
  assign in_idx     = AW'(in_channel);
  assign accept     = s_tvalid && s_tready;

  // channel memory and reset state per channel
  entry_t              mem [CHANNELS];
  logic [CHANNELS-1:0] ch_valid;
  logic [CHANNELS-1:0] ch_valid_next;

  // cell stage registers
  logic       s1_valid;
  logic       s1_first;
  logic       s1_eor;
  logic       s1_in_range;
  logic [5:0] s1_ch;
  logic [7:0] s1_note;
  logic [7:0] s1_ins;
  logic [7:0] s1_vol;
  logic [7:0] s1_cmd;
  logic [7:0] s1_val;
  entry_t     s1_rd;
  logic       s1_rd_ok;
  logic       s1_fwd_hit;
  logic       s1_fwd_clear;
  entry_t     s1_fwd_data;

  logic [AW-1:0] s1_idx;
  entry_t     eff;
  entry_t     upd;
  logic [7:0] mask;
  logic       active;
  logic       s1_wr;
  logic       s1_go;
  byte_buf_t  bytes;
  cnt_t       nb;
  logic [6:0] ch_code;
  ser_load_t  load;
  logic       ser_free;

  assign s1_idx = AW'(s1_ch);

  // effective entry: clear, forwarded write, memory or reset value
  always_comb begin
    priority if (s1_first) begin
      eff = ENTRY_RESET;
    end else if (s1_fwd_hit) begin
      eff = s1_fwd_data;
    end else if (s1_fwd_clear || !s1_rd_ok) begin
      eff = ENTRY_RESET;
    end else begin
      eff = s1_rd;
    end
  end

  // mask and updated entry
  always_comb begin
    mask   = '0;
    upd    = eff;
    active = s1_in_range &&
             !(s1_note == NOTE_NONE && s1_ins == INS_NONE && s1_vol == VOL_NONE &&
               s1_cmd == CMD_NONE && s1_val == VAL_NONE);
    if (s1_note != NOTE_NONE) begin
      if (eff.note != s1_note) begin
        upd.note = s1_note;
        mask[MASK_NEW_NOTE] = 1'b1;
      end else begin
        mask[MASK_REP_NOTE] = 1'b1;
      end
    end
    if (s1_ins != INS_NONE) begin
      if (eff.ins != s1_ins) begin
        upd.ins = s1_ins;
        mask[MASK_NEW_INS] = 1'b1;
      end else begin
        mask[MASK_REP_INS] = 1'b1;
      end
    end
    if (s1_vol != VOL_NONE) begin
      if (eff.vol != s1_vol) begin
        upd.vol = s1_vol;
        mask[MASK_NEW_VOL] = 1'b1;
      end else begin
        mask[MASK_REP_VOL] = 1'b1;
      end
    end
    if (s1_cmd != CMD_NONE || s1_val != VAL_NONE) begin
      if (eff.cmd != s1_cmd || eff.val != s1_val) begin
        upd.cmd = s1_cmd;
        upd.val = s1_val;
        mask[MASK_NEW_FX] = 1'b1;
      end else begin
        mask[MASK_REP_FX] = 1'b1;
      end
    end
    upd.mask = mask;
  end

  assign ch_code = 7'(s1_ch) + 7'd1;
  assign s1_wr   = s1_valid && active;

  // byte group of the cell
  always_comb begin
    bytes = '0;
    nb    = '0;
    if (active) begin
      if (eff.mask != mask) begin
        bytes[POS_W'(nb)] = {HEAD_MASK_FLAG, ch_code};
        nb = nb + cnt_t'(1);
        bytes[POS_W'(nb)] = mask;
        nb = nb + cnt_t'(1);
      end else begin
        bytes[POS_W'(nb)] = {1'b0, ch_code};
        nb = nb + cnt_t'(1);
      end
      if (mask[MASK_NEW_NOTE]) begin
        bytes[POS_W'(nb)] = s1_note;
        nb = nb + cnt_t'(1);
      end
      if (mask[MASK_NEW_INS]) begin
        bytes[POS_W'(nb)] = s1_ins;
        nb = nb + cnt_t'(1);
      end
      if (mask[MASK_NEW_VOL]) begin
        bytes[POS_W'(nb)] = s1_vol;
        nb = nb + cnt_t'(1);
      end
      if (mask[MASK_NEW_FX]) begin
        bytes[POS_W'(nb)] = s1_cmd;
        nb = nb + cnt_t'(1);
        bytes[POS_W'(nb)] = s1_val;
        nb = nb + cnt_t'(1);
      end
    end
    if (s1_eor) begin
      bytes[POS_W'(nb)] = ROW_END_BYTE;
      nb = nb + cnt_t'(1);
    end
  end

  // hand-off: cells with no bytes retire at once
  assign s1_go      = s1_valid && (nb == '0 || ser_free);
  assign s_tready   = !s1_valid || s1_go;
  assign load.valid = s1_valid && (nb != '0);
  assign load.cnt   = nb;
  assign load.bytes = bytes;

  // cell stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // cell stage payload and forwarding of the retiring cell
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch        <= in_channel;
      s1_note      <= s_tdata[13:6];
      s1_ins       <= s_tdata[21:14];
      s1_vol       <= s_tdata[29:22];
      s1_cmd       <= s_tdata[37:30];
      s1_val       <= s_tdata[45:38];
      s1_first     <= s_tuser;
      s1_eor       <= s_tlast;
      s1_in_range  <= in_range;
      s1_rd_ok     <= in_range ? ch_valid[in_idx] : 1'b0;
      s1_fwd_hit   <= s1_go && s1_wr && (s1_ch == in_channel);
      s1_fwd_clear <= s1_go && s1_first;
      s1_fwd_data  <= upd;
    end
  end

  // memory read port
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      s1_rd <= mem[in_idx];
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (s1_go && s1_wr) begin
      mem[s1_idx] <= upd;
    end
  end

  // per-channel valid bits, cleared by first_of_pattern
  always_comb begin
    ch_valid_next = ch_valid;
    if (s1_go) begin
      if (s1_first) begin
        ch_valid_next = '0;
      end
      if (s1_wr) begin
        ch_valid_next[s1_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= '0;
    end else begin
      ch_valid <= ch_valid_next;
    end
  end

  // output serializer
  pcmp_byte_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .free     (ser_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // a stalled cell keeps its fields and its memory view
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_ch) && $stable(s1_rd) &&
                           $stable(s1_fwd_hit) && $stable(s1_fwd_clear))
    else $error("cell stage changed while stalled");

  // a handed-off byte group shows up on the output in the next cycle
  a_load_out: assert property (@(posedge clk) disable iff (rst)
    s1_go && nb != '0 |=> m_tvalid)
    else $error("byte group lost at hand-off");

  // a cell that writes memory always sends at least its channel byte
  a_wr_bytes: assert property (@(posedge clk) disable iff (rst)
    s1_wr |-> nb != '0)
    else $error("memory update without output bytes");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// tb: self-checking testbench for pattern_cell_mask_packer_unit
// drives pattern cells on the slave stream and checks packed bytes against a local predictor
// depends on pcmp_pkg and the packer rtl
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcmp_pkg::*;

  localparam int N_CH     = 64;
  localparam int WD_LIMIT = 2000;
  localparam int TAIL     = 24;
  localparam int N_RAND   = 120;

  // one pattern cell plus the idle cycles that precede it on the bus
  typedef struct {
    logic        fop;
    logic [5:0]  ch;
    logic [7:0]  note;
    logic [7:0]  ins;
    logic [7:0]  vol;
    logic [7:0]  cmd;
    logic [7:0]  val;
    logic        eor;
    int unsigned gap;
  } cell_t;

  // one expected byte of the packed stream
  typedef struct {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  // per-channel memory of the last values sent
  typedef struct {
    logic [7:0] mask;
    logic [7:0] note;
    logic [7:0] ins;
    logic [7:0] vol;
    logic [7:0] cmd;
    logic [7:0] val;
  } chan_mem_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  cell_t        cell_q[$];
  packed_byte_t pending_bytes[$];
  chan_mem_t    chan_mem[N_CH];
  cell_t        cur_cell;
  int unsigned  tx_hold;
  int unsigned  rx_stall;
  int unsigned  rx_count;
  int unsigned  err_cnt;
  int unsigned  idle_cycles;
  bit           tx_calm;
  bit           timed_out;

  pattern_cell_mask_packer_unit #(
    .CHANNELS(N_CH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always #6 clk = ~clk;

  // channel memory back to its cleared values
  function automatic void clear_channels();
    foreach (chan_mem[i]) begin
      chan_mem[i] = '{mask: 8'd0, note: NOTE_NONE, ins: INS_NONE, vol: VOL_NONE,
                      cmd: CMD_NONE, val: VAL_NONE};
    end
  endfunction

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  // work out the bytes one accepted cell produces and queue them
  function automatic void pack_cell(cell_t c);
    logic [7:0] mask;
    logic [7:0] head;
    logic [7:0] bytes[$];
    logic       empty;
    int         idx;
    if (c.fop) clear_channels();
    empty = c.note == NOTE_NONE && c.ins == INS_NONE && c.vol == VOL_NONE &&
            c.cmd == CMD_NONE && c.val == VAL_NONE;
    idx = int'(c.ch);
    if (!empty && idx < N_CH) begin
      mask = '0;
      if (c.note != NOTE_NONE) begin
        if (chan_mem[idx].note != c.note) begin
          chan_mem[idx].note = c.note;
          mask[MASK_NEW_NOTE] = 1'b1;
        end else begin
          mask[MASK_REP_NOTE] = 1'b1;
        end
      end
      if (c.ins != INS_NONE) begin
        if (chan_mem[idx].ins != c.ins) begin
          chan_mem[idx].ins = c.ins;
          mask[MASK_NEW_INS] = 1'b1;
        end else begin
          mask[MASK_REP_INS] = 1'b1;
        end
      end
      if (c.vol != VOL_NONE) begin
        if (chan_mem[idx].vol != c.vol) begin
          chan_mem[idx].vol = c.vol;
          mask[MASK_NEW_VOL] = 1'b1;
        end else begin
          mask[MASK_REP_VOL] = 1'b1;
        end
      end
      // the effect is one pair: present if either byte is set
      if (c.cmd != CMD_NONE || c.val != VAL_NONE) begin
        if (chan_mem[idx].cmd != c.cmd || chan_mem[idx].val != c.val) begin
          chan_mem[idx].cmd = c.cmd;
          chan_mem[idx].val = c.val;
          mask[MASK_NEW_FX] = 1'b1;
        end else begin
          mask[MASK_REP_FX] = 1'b1;
        end
      end
      head = 8'(c.ch) + 8'd1;
      if (chan_mem[idx].mask != mask) begin
        chan_mem[idx].mask = mask;
        head[7] = HEAD_MASK_FLAG;
        bytes.push_back(head);
        bytes.push_back(mask);
      end else begin
        bytes.push_back(head);
      end
      if (mask[MASK_NEW_NOTE]) bytes.push_back(c.note);
      if (mask[MASK_NEW_INS]) bytes.push_back(c.ins);
      if (mask[MASK_NEW_VOL]) bytes.push_back(c.vol);
      if (mask[MASK_NEW_FX]) begin
        bytes.push_back(c.cmd);
        bytes.push_back(c.val);
      end
    end
    if (c.eor) bytes.push_back(ROW_END_BYTE);
    foreach (bytes[k]) pending_bytes.push_back('{data: bytes[k], last: k == bytes.size() - 1});
  endfunction

  function automatic int unsigned draw_gap();
    return tx_calm ? 0 : $urandom_range(0, 7);
  endfunction

  // none 4 times in 10, a small pool right above the none code 4 times in 10, else anything
  function automatic logic [7:0] rand_field(logic [7:0] none_val);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return none_val;
    if (r < 8) return none_val + 8'($urandom_range(1, 3));
    return 8'($urandom);
  endfunction

  task automatic add_cell(logic fop, logic [5:0] ch, logic [7:0] note, logic [7:0] ins,
                          logic [7:0] vol, logic [7:0] cmd, logic [7:0] val, logic eor);
    cell_q.push_back('{fop: fop, ch: ch, note: note, ins: ins, vol: vol, cmd: cmd,
                       val: val, eor: eor, gap: draw_gap()});
  endtask

  // slave side driver: presents queued cells, predicts each accepted one
  always @(posedge clk) begin : driver
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_hold = 0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        pack_cell(cur_cell);
        nv = 1'b0;
      end
      if (!nv && cell_q.size() != 0) begin
        if (tx_hold < cell_q[0].gap) begin
          tx_hold++;
        end else begin
          tx_hold  = 0;
          cur_cell = cell_q.pop_front();
          nv       = 1'b1;
        end
      end
      s_tvalid <= nv;
      if (nv) begin
        s_tdata <= {2'b00, cur_cell.val, cur_cell.cmd, cur_cell.vol, cur_cell.ins,
                    cur_cell.note, cur_cell.ch};
        s_tuser <= cur_cell.fop;
        s_tlast <= cur_cell.eor;
      end else begin
        s_tdata <= {16'($urandom), 32'($urandom)};
        s_tuser <= 1'($urandom);
        s_tlast <= 1'($urandom);
      end
    end
  end

  // master side monitor: random back-pressure, compares each byte with the oldest prediction
  always @(posedge clk) begin : monitor
    packed_byte_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall = 0;
      rx_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_bytes.size() == 0) begin
          flag_error($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
        end else begin
          want = pending_bytes.pop_front();
          if (m_tdata !== want.data || m_tlast !== want.last)
            flag_error($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                 rx_count, want.data, want.last, m_tdata, m_tlast));
        end
        rx_count++;
        // every third stretch of 40 bytes runs without back-pressure
        rx_stall = ((rx_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 7);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    logic [7:0] note;
    logic [7:0] ins;
    logic [7:0] vol;
    logic [7:0] cmd;
    logic [7:0] val;
    logic [5:0] ch;
    err_cnt = 0;
    clear_channels();

    // directed cells, back to back so same-channel cells hit the forwarding path
    tx_calm = 1'b1;
    add_cell(1'b0, 6'd0, NOTE_NONE, INS_NONE, VOL_NONE, CMD_NONE, VAL_NONE, 1'b0);
    add_cell(1'b0, 6'd7, NOTE_NONE, INS_NONE, VOL_NONE, CMD_NONE, VAL_NONE, 1'b1);
    add_cell(1'b0, 6'd0, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 1'b0);
    add_cell(1'b0, 6'd0, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 1'b0);
    add_cell(1'b0, 6'd0, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 1'b1);
    add_cell(1'b0, 6'd63, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 1'b1);
    add_cell(1'b0, 6'd63, NOTE_NONE, INS_NONE, VOL_NONE, CMD_NONE, 8'd7, 1'b0);
    add_cell(1'b0, 6'd63, NOTE_NONE, INS_NONE, VOL_NONE, CMD_NONE, 8'd7, 1'b0);
    add_cell(1'b0, 6'd63, NOTE_NONE, INS_NONE, VOL_NONE, CMD_NONE, 8'd8, 1'b0);
    add_cell(1'b0, 6'd63, NOTE_NONE, INS_NONE, VOL_NONE, 8'd8, 8'd8, 1'b0);
    add_cell(1'b0, 6'd5, 8'd252, INS_NONE, VOL_NONE, CMD_NONE, VAL_NONE, 1'b0);
    add_cell(1'b0, 6'd5, NOTE_NONE, 8'd128, VOL_NONE, CMD_NONE, VAL_NONE, 1'b0);
    add_cell(1'b0, 6'd5, NOTE_NONE, INS_NONE, 8'd0, CMD_NONE, VAL_NONE, 1'b0);
    add_cell(1'b0, 6'd5, NOTE_NONE, INS_NONE, 8'd0, CMD_NONE, VAL_NONE, 1'b1);
    add_cell(1'b1, 6'd0, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 1'b0);
    add_cell(1'b1, 6'd9, NOTE_NONE, INS_NONE, VOL_NONE, CMD_NONE, VAL_NONE, 1'b1);
    add_cell(1'b0, 6'd0, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 1'b0);
    add_cell(1'b0, 6'd42, 8'd254, 8'd2, 8'd254, 8'd1, 8'd1, 1'b0);
    add_cell(1'b0, 6'd42, 8'd254, 8'd3, 8'd254, 8'd1, 8'd1, 1'b1);
    add_cell(1'b0, 6'd42, 8'd0, 8'd3, 8'd1, 8'd2, 8'd1, 1'b0);
    add_cell(1'b0, 6'd62, 8'd1, 8'd255, 8'd1, 8'd255, 8'd0, 1'b0);
    tx_calm = 1'b0;
    add_cell(1'b0, 6'd62, 8'd1, 8'd255, 8'd1, 8'd255, 8'd0, 1'b1);

    // random cells: few channels and small value pools so repeats are common
    for (int i = 0; i < N_RAND; i++) begin
      tx_calm = (i >= 50 && i < 80);
      if ($urandom_range(0, 9) == 0) begin
        ch   = 6'($urandom);
        note = 8'($urandom);
        ins  = 8'($urandom);
        vol  = 8'($urandom);
        cmd  = 8'($urandom);
        val  = 8'($urandom);
      end else begin
        ch   = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
        note = rand_field(NOTE_NONE);
        ins  = rand_field(INS_NONE);
        vol  = rand_field(VOL_NONE);
        cmd  = rand_field(CMD_NONE);
        val  = rand_field(VAL_NONE);
      end
      add_cell($urandom_range(0, 15) == 0, ch, note, ins, vol, cmd, val,
               $urandom_range(0, 3) == 0);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // drain: all cells sent and every predicted byte seen
    while (!(cell_q.size() == 0 && !s_tvalid && pending_bytes.size() == 0) &&
           idle_cycles < WD_LIMIT)
      @(posedge clk);
    timed_out = idle_cycles >= WD_LIMIT;
    if (!timed_out) repeat (TAIL) @(posedge clk);
    if (pending_bytes.size() != 0)
      flag_error($sformatf("%0d predicted bytes never arrived", pending_bytes.size()));

    if (timed_out) begin
      $display("[pattern_cell_mask_packer_unit] ERROR");
    end else if (err_cnt == 0) begin
      $display("[pattern_cell_mask_packer_unit] OK");
    end else begin
      $display("[pattern_cell_mask_packer_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ pattern_cell_mask_packer_unit.f @@
rtl/pcmp_pkg.sv
rtl/pcmp_byte_ser.sv
rtl/pattern_cell_mask_packer_unit.sv
test/tb.sv
